[hw/rtl/swl_pkg.sv]
// shared types, field widths and codes of the sliding window limiter
`default_nettype none

package swl_pkg;

	// field widths of the channels
	localparam int FUNC_W    = 2;
	localparam int CLIENT_W  = 6;
	localparam int TIME_W    = 32;
	localparam int MAXREQ_W  = 7;
	localparam int COUNT_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	// defaults for the top level parameters
	localparam int CLIENTS_DEFAULT   = 64;
	localparam int LOG_DEPTH_DEFAULT = 64;

	// register values after reset
	localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 7'd60;
	localparam logic [TIME_W-1:0]   WINDOW_RESET = 32'd60;

	// function codes of a request
	localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'd1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_META,
		ST_PRUNE,
		ST_DECIDE,
		ST_RESULT
	} swl_state_t;

endpackage

`default_nettype wire

[hw/rtl/swl_if.sv]
// request, result and configuration channel interfaces
`default_nettype none

interface swl_item_if;
	logic                          valid;
	logic                          ready;
	logic [swl_pkg::FUNC_W-1:0]    func;
	logic [swl_pkg::CLIENT_W-1:0]  client;
	logic [swl_pkg::TIME_W-1:0]    now_time;

	modport source (output valid, func, client, now_time, input ready);
	modport sink   (input valid, func, client, now_time, output ready);
endinterface

interface swl_result_if;
	logic                          valid;
	logic                          ready;
	logic                          allowed;
	logic [swl_pkg::COUNT_W-1:0]   logged_count;

	modport source (output valid, allowed, logged_count, input ready);
	modport sink   (input valid, allowed, logged_count, output ready);
endinterface

interface swl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [swl_pkg::CFG_IDX_W-1:0]  index;
	logic [swl_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/swl_client_table.sv]
// per-client ring pointer and entry count memory
`default_nettype none

module swl_client_table #(
	parameter int CLIENTS = 64,
	parameter int CL_W    = 6,
	parameter int SLOT_W  = 6,
	parameter int CNT_W   = 7
) (
	input  wire logic              clk,
	input  wire logic              re,
	input  wire logic [CL_W-1:0]   raddr,
	input  wire logic              we,
	input  wire logic [CL_W-1:0]   waddr,
	input  wire logic [SLOT_W-1:0] whead,
	input  wire logic [CNT_W-1:0]  wcnt,
	output logic      [SLOT_W-1:0] rhead,
	output logic      [CNT_W-1:0]  rcnt
);

	localparam int ROW_W = SLOT_W + CNT_W;

	logic [ROW_W-1:0] mem [CLIENTS];
	logic [ROW_W-1:0] rd_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {whead, wcnt};
		if (re)
			rd_q <= mem[raddr];
	end

	// unpack the row
	assign rhead = rd_q[ROW_W-1:CNT_W];
	assign rcnt  = rd_q[CNT_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/swl_stamp_log.sv]
// timestamp log memory with the window expiry check on its read port
`default_nettype none

module swl_stamp_log #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  wire logic                        clk,
	input  wire logic                        re,
	input  wire logic [ADDR_W-1:0]           raddr,
	input  wire logic                        we,
	input  wire logic [ADDR_W-1:0]           waddr,
	input  wire logic [swl_pkg::TIME_W-1:0]  wdata,
	input  wire logic [swl_pkg::TIME_W-1:0]  now_time,
	input  wire logic [swl_pkg::TIME_W-1:0]  window_ticks,
	output logic                             expired
);

	import swl_pkg::*;

	logic [TIME_W-1:0] mem [DEPTH];
	logic [TIME_W-1:0] rd_q;
	logic [TIME_W-1:0] age;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	// age modulo 2^32 against the window
	assign age     = now_time - rd_q;
	assign expired = age > window_ticks;

endmodule

`default_nettype wire

[hw/rtl/per_client_sliding_window_limiter.sv]
// top level of the per-client sliding window request limiter
//
//  channel  | role  | fields                    | taken when
//  item     | sink  | func, client, now_time    | valid & ready
//  result   | src   | allowed, logged_count     | valid & ready
//  cfg      | sink  | index, data               | valid & ready (ready held high)
//
// a request on an empty log goes from the client table read straight to the
// decision; otherwise the oldest expired log entries are dropped one by one,
// walked through the single read port of the timestamp memory; a query only
// reads the client table. a clear sweeps the client table one row a cycle.
// after reset the same sweep runs with item.ready low.
// the result register lets the next request in while a result is stalled.
`default_nettype none

module per_client_sliding_window_limiter #(
	parameter int CLIENTS   = swl_pkg::CLIENTS_DEFAULT,
	parameter int LOG_DEPTH = swl_pkg::LOG_DEPTH_DEFAULT
) (
	input wire logic   clk,
	input wire logic   arst_n,
	swl_item_if.sink   item,
	swl_result_if.source result,
	swl_cfg_if.sink    cfg
);

	import swl_pkg::*;

	localparam int CL_W    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int SLOT_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
	localparam int LIM_W   = (CNT_W > MAXREQ_W) ? CNT_W : MAXREQ_W;
	localparam int SUM_W   = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
	localparam int SADDR_W = CL_W + SLOT_W;
	localparam int SDEPTH  = CLIENTS * (2 ** SLOT_W);

	// configuration registers
	logic [MAXREQ_W-1:0] max_q;
	logic [TIME_W-1:0]   window_q;

	// captured request
	logic [FUNC_W-1:0] func_q;
	logic [CL_W-1:0]   client_idx_q;
	logic              in_range_q;
	logic [TIME_W-1:0] now_q;

	// sequencer state
	swl_state_t        state_q, state_d;
	logic [SLOT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              res_allowed_q, res_allowed_d;
	logic [COUNT_W-1:0] res_count_q, res_count_d;
	logic [CL_W-1:0]   clr_idx_q, clr_idx_d;
	logic              clr_report_q, clr_report_d;

	// result register
	logic               out_valid_q;
	logic               out_allowed_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_free;
	logic               out_load;

	// memory ports
	logic              meta_re, meta_we;
	logic [CL_W-1:0]   meta_waddr;
	logic [SLOT_W-1:0] meta_whead, meta_rhead;
	logic [CNT_W-1:0]  meta_wcnt, meta_rcnt;
	logic              stamp_re, stamp_we, stamp_expired;
	logic [SADDR_W-1:0] stamp_raddr;

	// ring arithmetic and limit
	logic              item_acc;
	logic              item_in_range;
	logic [SUM_W-1:0]  tail_sum;
	logic [SLOT_W-1:0] tail;
	logic [SLOT_W-1:0] head_inc;
	logic [LIM_W-1:0]  limit;
	logic              under_limit;

	assign item_acc      = item.valid && item.ready;
	assign item_in_range = 32'(item.client) < 32'(CLIENTS);
	assign meta_re       = item_acc && item_in_range;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAXREQ_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAX_REQUESTS: max_q    <= cfg.data[MAXREQ_W-1:0];
				CFG_WINDOW_TICKS: window_q <= cfg.data;
			endcase
		end
	end

	// capture the accepted request
	always_ff @(posedge clk) begin
		if (item_acc) begin
			func_q       <= item.func;
			client_idx_q <= CL_W'(item.client);
			in_range_q   <= item_in_range;
			now_q        <= item.now_time;
		end
	end

	// ring helpers
	assign tail_sum = SUM_W'(head_q) + SUM_W'(cnt_q);
	assign tail     = (tail_sum >= SUM_W'(LOG_DEPTH)) ? SLOT_W'(tail_sum - SUM_W'(LOG_DEPTH))
	                                                  : SLOT_W'(tail_sum);
	assign head_inc = (head_q == SLOT_W'(LOG_DEPTH - 1)) ? '0 : head_q + SLOT_W'(1);

	// limit saturates at the log depth
	assign limit = (LIM_W'(max_q) > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH) : LIM_W'(max_q);
	assign under_limit = LIM_W'(cnt_q) < limit;

	assign out_free = !out_valid_q || result.ready;

	// next state and memory control
	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		cnt_d         = cnt_q;
		res_allowed_d = res_allowed_q;
		res_count_d   = res_count_q;
		clr_idx_d     = clr_idx_q;
		clr_report_d  = clr_report_q;
		meta_we       = 1'b0;
		meta_waddr    = client_idx_q;
		meta_whead    = head_q;
		meta_wcnt     = cnt_q;
		stamp_re      = 1'b0;
		stamp_raddr   = {client_idx_q, head_q};
		stamp_we      = 1'b0;
		out_load      = 1'b0;
		item.ready    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_idx_q;
				meta_whead = '0;
				meta_wcnt  = '0;
				if (clr_idx_q == CL_W'(CLIENTS - 1)) begin
					clr_idx_d = '0;
					if (clr_report_q) begin
						res_allowed_d = 1'b0;
						res_count_d   = '0;
						state_d       = ST_RESULT;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					clr_idx_d = clr_idx_q + CL_W'(1);
				end
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (item.func == FUNC_CLEAR) begin
						clr_report_d = 1'b1;
						state_d      = ST_CLEAR;
					end else begin
						state_d = ST_META;
					end
				end
			end
			ST_META: begin
				head_d = meta_rhead;
				cnt_d  = meta_rcnt;
				if (func_q == FUNC_REQUEST && in_range_q) begin
					if (meta_rcnt == '0) begin
						head_d  = '0;
						state_d = ST_DECIDE;
					end else begin
						stamp_re    = 1'b1;
						stamp_raddr = {client_idx_q, meta_rhead};
						state_d     = ST_PRUNE;
					end
				end else begin
					// query, unused code or unknown client
					res_allowed_d = 1'b0;
					res_count_d   = in_range_q ? COUNT_W'(meta_rcnt) : '0;
					state_d       = ST_RESULT;
				end
			end
			ST_PRUNE: begin
				// drop oldest entries while they lie outside the window
				if (stamp_expired) begin
					if (cnt_q == CNT_W'(1)) begin
						cnt_d   = '0;
						head_d  = '0;
						state_d = ST_DECIDE;
					end else begin
						cnt_d       = cnt_q - CNT_W'(1);
						head_d      = head_inc;
						stamp_re    = 1'b1;
						stamp_raddr = {client_idx_q, head_inc};
					end
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				meta_we = 1'b1;
				if (under_limit) begin
					stamp_we      = 1'b1;
					meta_wcnt     = cnt_q + CNT_W'(1);
					res_allowed_d = 1'b1;
					res_count_d   = COUNT_W'(cnt_q + CNT_W'(1));
				end else begin
					res_allowed_d = 1'b0;
					res_count_d   = COUNT_W'(cnt_q);
				end
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			clr_report_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_idx_q    <= clr_idx_d;
			clr_report_q <= clr_report_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q        <= head_d;
		cnt_q         <= cnt_d;
		res_allowed_q <= res_allowed_d;
		res_count_q   <= res_count_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_allowed_q <= res_allowed_q;
			out_count_q   <= res_count_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.allowed      = out_allowed_q;
	assign result.logged_count = out_count_q;

	// per-client ring pointer and count
	swl_client_table #(
		.CLIENTS (CLIENTS),
		.CL_W    (CL_W),
		.SLOT_W  (SLOT_W),
		.CNT_W   (CNT_W)
	) u_client_table (
		.clk   (clk),
		.re    (meta_re),
		.raddr (CL_W'(item.client)),
		.we    (meta_we),
		.waddr (meta_waddr),
		.whead (meta_whead),
		.wcnt  (meta_wcnt),
		.rhead (meta_rhead),
		.rcnt  (meta_rcnt)
	);

	// timestamp log
	swl_stamp_log #(
		.DEPTH  (SDEPTH),
		.ADDR_W (SADDR_W)
	) u_stamp_log (
		.clk          (clk),
		.re           (stamp_re),
		.raddr        (stamp_raddr),
		.we           (stamp_we),
		.waddr        ({client_idx_q, tail}),
		.wdata        (now_q),
		.now_time     (now_q),
		.window_ticks (window_q),
		.expired      (stamp_expired)
	);

endmodule

`default_nettype wire
